/* rtl/wsbp_pkg.sv */
package wsbp_pkg;

  localparam int DEFAULT_SIZE_BITS = 32;
  localparam int HDR_LEN = 8;
  localparam int HDR_COUNT_W = $clog2(HDR_LEN);
  localparam int MAX_RESULTS = 3;
  localparam int RES_COUNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [31:0] NAME_VTTC = 32'h7674_7463;
  localparam logic [31:0] NAME_IDEN = 32'h6964_656E;
  localparam logic [31:0] NAME_STTG = 32'h7374_7467;
  localparam logic [31:0] NAME_PAYL = 32'h7061_796C;

  typedef enum logic [1:0] {
    MODE_TOP_HDR,
    MODE_TOP_SKIP,
    MODE_CHILD_HDR,
    MODE_CHILD_BODY
  } mode_t;

  typedef enum logic [1:0] {
    FIELD_NONE,
    FIELD_IDEN,
    FIELD_STTG,
    FIELD_PAYL
  } field_t;

  typedef enum logic [2:0] {
    KIND_IDEN,
    KIND_STTG,
    KIND_PAYL,
    KIND_CUE_END,
    KIND_SAMPLE_END
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       status;
    logic       run_last;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] slot;
    logic [RES_COUNT_W-1:0]    count;
  } emit_t;

  function automatic field_t field_of_name(input logic [31:0] name);
    field_t f;
    case (name)
      NAME_IDEN: f = FIELD_IDEN;
      NAME_STTG: f = FIELD_STTG;
      NAME_PAYL: f = FIELD_PAYL;
      default:   f = FIELD_NONE;
    endcase
    return f;
  endfunction

  function automatic kind_t kind_of_field(input field_t f);
    kind_t k;
    case (f)
      FIELD_IDEN: k = KIND_IDEN;
      FIELD_STTG: k = KIND_STTG;
      FIELD_PAYL: k = KIND_PAYL;
      default:    k = KIND_PAYL;
    endcase
    return k;
  endfunction

endpackage

/* rtl/wsbp_in_if.sv */
interface wsbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       sample_last;

  modport source (output valid, output data_byte, output sample_last, input ready);
  modport sink (input valid, input data_byte, input sample_last, output ready);
endinterface

/* rtl/wsbp_out_if.sv */
interface wsbp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;
  logic       status;
  logic       run_last;

  modport source (output valid, output kind, output value, output status, output run_last,
                  input ready);
  modport sink (input valid, input kind, input value, input status, input run_last,
                output ready);
endinterface

/* rtl/webvtt_sample_box_parser_core.sv */
// Walks the box structure of one WebVTT sample carried in an ISO BMFF track.
// The sample_ch channel takes one sample byte per item, with sample_last set
// on the final byte. The result_ch channel gives the tagged bytes of the
// iden, sttg and payl children of every vttc box, a cue end when each vttc
// closes, and a sample end after the last byte, with run_last marking the
// final result caused by a byte. One byte can cause up to three results.
// A byte is processed in the cycle it is accepted and its results appear on
// result_ch in the next cycle; while result_ch takes each result, a byte
// causing one result or none is taken every cycle, so the sustained rate is
// one byte per cycle. A byte causing two or three results holds sample_ch
// off until the three-entry result buffer has drained to its last entry.
// When result_ch stalls, results wait in the buffer, and sample_ch.ready
// drops while the buffer holds more than one result or holds one result
// that result_ch does not take in that cycle.
// Reset clears the walker to wait for a top-level header and empties the
// result buffer; every sample end also returns the walker to that state.
module webvtt_sample_box_parser_core #(
  parameter int SIZE_BITS = wsbp_pkg::DEFAULT_SIZE_BITS
) (
  input logic clk,
  input logic rst,
  wsbp_in_if.sink    sample_ch,
  wsbp_out_if.source result_ch
);
  import wsbp_pkg::*;

  logic    take;
  logic    can_load;
  emit_t   emit;
  result_t head;

  assign take            = sample_ch.valid && can_load;
  assign sample_ch.ready = can_load;

  wsbp_walker #(
    .SIZE_BITS(SIZE_BITS)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (sample_ch.data_byte),
    .sample_last(sample_ch.sample_last),
    .emit       (emit)
  );

  wsbp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .load_data (emit),
    .head_ready(result_ch.ready),
    .head_valid(result_ch.valid),
    .head      (head),
    .can_load  (can_load)
  );

  assign result_ch.kind     = head.kind;
  assign result_ch.value    = head.value;
  assign result_ch.status   = head.status;
  assign result_ch.run_last = head.run_last;

  a_end_follows_last: assert property (@(posedge clk) disable iff (rst)
    take && sample_ch.sample_last |=> result_ch.valid)
    else $error("sample end did not follow the last byte");

  a_stall_means_pending: assert property (@(posedge clk) disable iff (rst)
    !sample_ch.ready |-> result_ch.valid)
    else $error("input held off with no result pending");

  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.kind == KIND_SAMPLE_END |-> result_ch.run_last)
    else $error("sample end is not the last result of its byte");

  a_status_on_end_only: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.kind != KIND_SAMPLE_END |-> !result_ch.status)
    else $error("error status on a result other than sample end");

endmodule

/* rtl/wsbp_walker.sv */
module wsbp_walker #(
  parameter int SIZE_BITS = wsbp_pkg::DEFAULT_SIZE_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      data_byte,
  input  logic            sample_last,
  output wsbp_pkg::emit_t emit
);
  import wsbp_pkg::*;

  localparam logic [HDR_COUNT_W-1:0] COUNT_SIZE_DONE = HDR_COUNT_W'(HDR_LEN / 2 - 1);
  localparam logic [HDR_COUNT_W-1:0] COUNT_HDR_DONE = HDR_COUNT_W'(HDR_LEN - 1);

  logic [31:0]            header_shift, header_shift_next;
  logic [HDR_COUNT_W-1:0] header_count, header_count_next;
  logic                   size_over, size_over_next;
  logic [SIZE_BITS-1:0]   outer_remaining, outer_remaining_next;
  logic [SIZE_BITS-1:0]   inner_remaining, inner_remaining_next;
  mode_t                  level_mode, level_mode_next, mode_work;
  field_t                 child_field, child_field_next;
  logic                   error_seen, error_seen_next, err_work;

  logic [31:0]          shift_new;
  logic                 shift_over;
  logic                 count_is_size, hdr_done;
  logic [SIZE_BITS-1:0] hdr_size, size_body, outer_dec, inner_dec;
  logic                 hdr_bad, child_err;
  logic                 byte_evt, cue_evt;

  assign shift_new     = {header_shift[23:0], data_byte};
  assign shift_over    = (shift_new >> SIZE_BITS) != '0;
  assign count_is_size = header_count == COUNT_SIZE_DONE;
  assign hdr_done      = header_count == COUNT_HDR_DONE;
  assign hdr_size      = (level_mode == MODE_TOP_HDR) ? outer_remaining : inner_remaining;
  assign size_body     = hdr_size - SIZE_BITS'(HDR_LEN);
  assign outer_dec     = outer_remaining - 1'b1;
  assign inner_dec     = inner_remaining - 1'b1;
  assign hdr_bad       = (hdr_size < SIZE_BITS'(HDR_LEN)) || (shift_new == '0) || size_over;
  assign child_err     = hdr_done && (hdr_bad || (size_body > outer_dec));

  always_comb begin
    header_shift_next    = header_shift;
    header_count_next    = header_count;
    size_over_next       = size_over;
    outer_remaining_next = outer_remaining;
    inner_remaining_next = inner_remaining;
    mode_work            = level_mode;
    child_field_next     = child_field;
    err_work             = error_seen;
    if (!error_seen) begin
      case (level_mode)
        MODE_TOP_HDR: begin
          header_shift_next = shift_new;
          header_count_next = header_count + 1'b1;
          if (count_is_size) begin
            outer_remaining_next = shift_new[SIZE_BITS-1:0];
            size_over_next       = shift_over;
          end else if (hdr_done) begin
            header_count_next = '0;
            if (hdr_bad) begin
              err_work             = 1'b1;
              outer_remaining_next = '0;
            end else begin
              outer_remaining_next = size_body;
              if (shift_new == NAME_VTTC) begin
                if (size_body != '0) mode_work = MODE_CHILD_HDR;
              end else if (size_body != '0) begin
                mode_work = MODE_TOP_SKIP;
              end
            end
          end
        end
        MODE_TOP_SKIP: begin
          outer_remaining_next = outer_dec;
          if (outer_dec == '0) mode_work = MODE_TOP_HDR;
        end
        MODE_CHILD_HDR: begin
          outer_remaining_next = outer_dec;
          header_shift_next    = shift_new;
          header_count_next    = header_count + 1'b1;
          if (count_is_size) begin
            inner_remaining_next = shift_new[SIZE_BITS-1:0];
            size_over_next       = shift_over;
          end else if (hdr_done) begin
            header_count_next = '0;
            if (child_err) begin
              err_work             = 1'b1;
              inner_remaining_next = '0;
            end else begin
              inner_remaining_next = size_body;
              child_field_next     = field_of_name(shift_new);
              if (size_body != '0) mode_work = MODE_CHILD_BODY;
            end
          end
          if (!child_err && outer_dec == '0) begin
            header_count_next = '0;
            child_field_next  = FIELD_NONE;
            mode_work         = MODE_TOP_HDR;
          end
        end
        MODE_CHILD_BODY: begin
          outer_remaining_next = outer_dec;
          inner_remaining_next = inner_dec;
          if (inner_dec == '0) begin
            child_field_next = FIELD_NONE;
            mode_work        = MODE_CHILD_HDR;
          end
          if (outer_dec == '0) begin
            header_count_next = '0;
            mode_work         = MODE_TOP_HDR;
          end
        end
        default: begin
          mode_work = level_mode;
        end
      endcase
    end
    level_mode_next = mode_work;
    error_seen_next = err_work;
    if (sample_last) begin
      header_shift_next    = '0;
      header_count_next    = '0;
      size_over_next       = 1'b0;
      outer_remaining_next = '0;
      inner_remaining_next = '0;
      level_mode_next      = MODE_TOP_HDR;
      child_field_next     = FIELD_NONE;
      error_seen_next      = 1'b0;
    end
  end

  assign byte_evt = !error_seen && level_mode == MODE_CHILD_BODY && child_field != FIELD_NONE;
  assign cue_evt  = !error_seen && (
      (level_mode == MODE_TOP_HDR && hdr_done && !hdr_bad && shift_new == NAME_VTTC &&
       size_body == '0) ||
      (level_mode == MODE_CHILD_HDR && !child_err && outer_dec == '0) ||
      (level_mode == MODE_CHILD_BODY && outer_dec == '0));

  always_comb begin
    emit = '0;
    if (byte_evt) begin
      emit.slot[emit.count].kind  = kind_of_field(child_field);
      emit.slot[emit.count].value = data_byte;
      emit.count                  = emit.count + 1'b1;
    end
    if (cue_evt) begin
      emit.slot[emit.count].kind = KIND_CUE_END;
      emit.count                 = emit.count + 1'b1;
    end
    if (sample_last) begin
      emit.slot[emit.count].kind   = KIND_SAMPLE_END;
      emit.slot[emit.count].status = err_work || (mode_work != MODE_TOP_HDR);
      emit.count                   = emit.count + 1'b1;
    end
    if (emit.count != '0) begin
      emit.slot[emit.count - 1'b1].run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_shift    <= '0;
      header_count    <= '0;
      size_over       <= 1'b0;
      outer_remaining <= '0;
      inner_remaining <= '0;
      level_mode      <= MODE_TOP_HDR;
      child_field     <= FIELD_NONE;
      error_seen      <= 1'b0;
    end else if (take) begin
      header_shift    <= header_shift_next;
      header_count    <= header_count_next;
      size_over       <= size_over_next;
      outer_remaining <= outer_remaining_next;
      inner_remaining <= inner_remaining_next;
      level_mode      <= level_mode_next;
      child_field     <= child_field_next;
      error_seen      <= error_seen_next;
    end
  end

endmodule

/* rtl/wsbp_out_buf.sv */
module wsbp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  wsbp_pkg::emit_t   load_data,
  input  logic              head_ready,
  output logic              head_valid,
  output wsbp_pkg::result_t head,
  output logic              can_load
);
  import wsbp_pkg::*;

  result_t [MAX_RESULTS-1:0] slot;
  logic [RES_COUNT_W-1:0]    count;
  logic                      pop;

  assign head_valid = count != '0;
  assign head       = slot[0];
  assign pop        = head_valid && head_ready;
  assign can_load   = (count == '0) || (count == RES_COUNT_W'(1) && head_ready);

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= load_data.slot;
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= load_data.count;
    end else if (pop) begin
      count <= count - 1'b1;
    end
  end

endmodule
